[src/tree_lca_binary_lifting_core_assert.svh]
// Assertion macros for the tree ancestor core.
// Depends on nothing; the user scope must provide clk and rst_n.
`ifndef TREE_LCA_BINARY_LIFTING_CORE_ASSERT_SVH
`define TREE_LCA_BINARY_LIFTING_CORE_ASSERT_SVH

// Same-cycle implication, held off while in reset.
`define TLCA_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tlca check failed");

// Next-cycle implication, held off while in reset.
`define TLCA_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tlca check failed");

`endif

[src/tlca_pkg.sv]
// Shared types and constants for the tree ancestor core.
// No dependencies.
`default_nettype none
package tlca_pkg;

    localparam int NODE_W        = 10;
    localparam int STEPS_W       = 10;
    localparam int ACT_W         = 2;
    localparam int STAT_W        = 2;
    localparam int MAX_NODES_DEF = 1023;
    localparam int LEVELS_DEF    = 10;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_BUILD = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_NODE  = 2'd1,
        ST_NOT_BUILT = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        CFG_NODE_COUNT = 1'b0,
        CFG_ROOT_NODE  = 1'b1
    } cfg_idx_t;

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_DECODE, S_REPLY,
        S_E_RDA, S_E_WRA, S_E_RDB, S_E_WRB,
        S_B_CLR, S_B_ROOT, S_B_HEAD, S_B_HEADD, S_B_DONE,
        S_P_W0, S_P_CHK, S_P_WR,
        S_W_TOP, S_W_POP, S_W_EDGE, S_W_VIS, S_W_PUSH, S_W_HEAD,
        S_Q_RDA, S_Q_RDB, S_Q_SET, S_Q_UP, S_Q_UPD, S_Q_EQ,
        S_Q_LU, S_Q_LV, S_Q_LC, S_Q_LF, S_Q_LFD, S_Q_K, S_Q_KU, S_Q_KD
    } tlca_state_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [NODE_W-1:0]  node_a;
        logic [NODE_W-1:0]  node_b;
        logic [STEPS_W-1:0] steps;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] common_ancestor;
        logic [NODE_W-1:0] kth_ancestor;
        logic              kth_found;
        logic [NODE_W-1:0] depth_a;
        logic [STAT_W-1:0] status;
    } res_t;

    // Lifting table entry: ok clear means "no ancestor".
    typedef struct packed {
        logic              ok;
        logic [NODE_W-1:0] node;
    } anc_t;

endpackage
`default_nettype wire

[src/tlca_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tlca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[src/tree_lca_binary_lifting_core.sv]
// Tree ancestor core: edge store, depth-first table build, LCA / k-th queries.
// Depends on tlca_pkg, tlca_ram and tree_lca_binary_lifting_core_assert.svh.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------
//  request  | start, busy           | request (req_t)
//  result   | done (one-cycle)      | result (res_t)
//  config   | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
//  After reset all 2**clog2(MAX_NODES+1) adjacency heads are swept clear
//  with busy high; config writes are taken throughout.
//  Add edge: read and rewrite the head of each end in turn. Query: lifting
//  table reads go one at a time through the single read port of its memory.
//  Build: a sweep of the lifting table and depths, then a depth-first walk
//  that fills the lifting column of each reached node, one level per read,
//  and skips stored edges that reach no new node.
//  Results cannot be stalled: done is high for exactly one cycle.
`default_nettype none
`include "tree_lca_binary_lifting_core_assert.svh"
module tree_lca_binary_lifting_core #(
    parameter int MAX_NODES = tlca_pkg::MAX_NODES_DEF,
    parameter int LEVELS    = tlca_pkg::LEVELS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  tlca_pkg::req_t            request,
    output logic                      done,
    output tlca_pkg::res_t            result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  tlca_pkg::cfg_idx_t        cfg_index,
    input  logic [tlca_pkg::NODE_W-1:0] cfg_data
);
    import tlca_pkg::*;

    localparam int SLOTS    = MAX_NODES + 1;
    localparam int AW       = $clog2(SLOTS);
    localparam int MEM_D    = 1 << AW;
    localparam int EDGE_CAP = 2 * SLOTS;
    localparam int LW       = $clog2(EDGE_CAP + 1);
    localparam int LVW      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int TAW      = LVW + AW;
    localparam int LCW      = $clog2(LEVELS + 1);
    localparam int DW       = AW;
    localparam int SW       = AW + 1;
    localparam int ANC_W    = NODE_W + 1;
    localparam int STK_W    = NODE_W + LW + DW;

    // Control state
    tlca_state_t          state_reg, state_next, ret_reg, ret_next;
    logic [NODE_W-1:0]    node_count_reg, node_count_next;
    logic [NODE_W-1:0]    root_reg, root_next;
    logic [LW-1:0]        edge_count_reg, edge_count_next;
    logic                 built_reg, built_next;
    logic [TAW-1:0]       clr_reg, clr_next;
    logic [SW-1:0]        sp_reg, sp_next;
    logic                 done_reg, done_next;

    // Working registers
    req_t                 req_reg, req_next;
    logic [NODE_W-1:0]    here_reg, here_next, nb_reg, nb_next, px_reg, px_next;
    logic [LW-1:0]        link_reg, link_next;
    logic [DW-1:0]        hdep_reg, hdep_next, da_reg, da_next, diff_reg, diff_next;
    anc_t                 cur_reg, cur_next, du_reg, du_next;
    logic [LCW-1:0]       lvl_reg, lvl_next;
    logic [NODE_W-1:0]    u_reg, u_next, v_reg, v_next;
    logic [NODE_W-1:0]    lca_reg, lca_next, kth_reg, kth_next;
    logic                 found_reg, found_next;
    status_t              st_reg, st_next;
    res_t                 result_reg, result_next;

    // Memory ports
    logic                 head_we;
    logic [AW-1:0]        head_waddr, head_raddr;
    logic [LW-1:0]        head_wdata, head_rdata;
    logic                 tgt_we;
    logic [$clog2(EDGE_CAP)-1:0] edge_waddr, edge_raddr;
    logic [NODE_W-1:0]    tgt_wdata, tgt_rdata;
    logic [LW-1:0]        nxt_wdata, nxt_rdata;
    logic                 stk_we;
    logic [AW-1:0]        stk_waddr, stk_raddr;
    logic [STK_W-1:0]     stk_wdata, stk_rdata;
    logic                 anc_we;
    logic [TAW-1:0]       anc_waddr, anc_raddr;
    anc_t                 anc_wdata, anc_rdata;
    logic                 dep_we;
    logic [AW-1:0]        dep_waddr, dep_raddr;
    logic [DW-1:0]        dep_wdata, dep_rdata;

    // Helpers
    logic                 a_ok, b_ok, root_ok, tgt_ok;
    logic [LW-1:0]        link_dec, ec_inc, ec_inc2;
    logic [SW-1:0]        sp_dec, sp_dec2;
    logic [LCW-1:0]       lvl_dec;
    logic [DW-1:0]        diff_shift;
    logic [STEPS_W-1:0]   k_shift;
    logic                 link_end, clr_last, init_last, k_ok, lvl_end;
    logic [DW-1:0]        db;

    function automatic logic node_valid(input logic [NODE_W-1:0] x,
                                        input logic [NODE_W-1:0] cnt);
        node_valid = (x != '0) && (x <= cnt) && (32'(x) <= MAX_NODES);
    endfunction

    function automatic logic [TAW-1:0] anc_addr(input logic [LCW-1:0] l,
                                                input logic [NODE_W-1:0] n);
        anc_addr = {l[LVW-1:0], AW'(n)};
    endfunction

    assign a_ok       = node_valid(req_reg.node_a, node_count_reg);
    assign b_ok       = node_valid(req_reg.node_b, node_count_reg);
    assign root_ok    = node_valid(root_reg, node_count_reg);
    assign tgt_ok     = node_valid(tgt_rdata, node_count_reg);
    assign link_dec   = link_reg - LW'(1);
    assign ec_inc     = edge_count_reg + LW'(1);
    assign ec_inc2    = edge_count_reg + LW'(2);
    assign sp_dec     = sp_reg - SW'(1);
    assign sp_dec2    = sp_reg - SW'(2);
    assign lvl_dec    = lvl_reg - LCW'(1);
    assign diff_shift = diff_reg >> lvl_reg;
    assign k_shift    = req_reg.steps >> lvl_reg;
    assign link_end   = (link_reg == '0) || (link_reg > edge_count_reg);
    assign clr_last   = (clr_reg == {LVW'(LEVELS - 1), {AW{1'b1}}});
    assign init_last  = &clr_reg[AW-1:0];
    assign lvl_end    = (32'(lvl_reg) == LEVELS);
    assign k_ok       = (32'(req_reg.steps) <= 32'(da_reg))
                        && ((32'(req_reg.steps) >> LEVELS) == 0);
    assign db         = dep_rdata;

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // Memories
    tlca_ram #(.WIDTH(LW), .DEPTH(MEM_D)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata));
    tlca_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_CAP)) u_tgt (
        .clk(clk), .we(tgt_we), .waddr(edge_waddr), .wdata(tgt_wdata),
        .raddr(edge_raddr), .rdata(tgt_rdata));
    tlca_ram #(.WIDTH(LW), .DEPTH(EDGE_CAP)) u_nxt (
        .clk(clk), .we(tgt_we), .waddr(edge_waddr), .wdata(nxt_wdata),
        .raddr(edge_raddr), .rdata(nxt_rdata));
    tlca_ram #(.WIDTH(STK_W), .DEPTH(MEM_D)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata));
    tlca_ram #(.WIDTH(ANC_W), .DEPTH(1 << TAW)) u_anc (
        .clk(clk), .we(anc_we), .waddr(anc_waddr), .wdata(anc_wdata),
        .raddr(anc_raddr), .rdata(anc_rdata));
    tlca_ram #(.WIDTH(DW), .DEPTH(MEM_D)) u_dep (
        .clk(clk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
        .raddr(dep_raddr), .rdata(dep_rdata));

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:    if (init_last) state_next = S_IDLE;
            S_IDLE:    if (start) state_next = S_DECODE;
            S_DECODE:
            begin
                case (req_reg.action)
                    ACT_ADD:
                        if (!a_ok || !b_ok) state_next = S_REPLY;
                        else if ((32'(edge_count_reg) + 2) <= EDGE_CAP) state_next = S_E_RDA;
                        else state_next = S_REPLY;
                    ACT_BUILD: state_next = root_ok ? S_B_CLR : S_REPLY;
                    ACT_QUERY: state_next = (a_ok && b_ok && built_reg) ? S_Q_RDA : S_REPLY;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_REPLY:   state_next = S_IDLE;
            S_E_RDA:   state_next = S_E_WRA;
            S_E_WRA:   state_next = S_E_RDB;
            S_E_RDB:   state_next = S_E_WRB;
            S_E_WRB:   state_next = S_REPLY;
            S_B_CLR:   if (clr_last) state_next = S_B_ROOT;
            S_B_ROOT:  state_next = S_P_W0;
            S_B_HEAD:  state_next = S_B_HEADD;
            S_B_HEADD: state_next = S_W_TOP;
            S_B_DONE:  state_next = S_REPLY;
            S_P_W0:    state_next = S_P_CHK;
            S_P_CHK:   state_next = (lvl_end || !cur_reg.ok) ? ret_reg : S_P_WR;
            S_P_WR:    state_next = S_P_CHK;
            S_W_TOP:
                if (!link_end) state_next = S_W_EDGE;
                else if (sp_reg <= SW'(1)) state_next = S_B_DONE;
                else state_next = S_W_POP;
            S_W_POP:   state_next = S_W_TOP;
            S_W_EDGE:  state_next = tgt_ok ? S_W_VIS : S_W_TOP;
            S_W_VIS:   state_next = anc_rdata.ok ? S_W_TOP : S_P_W0;
            S_W_PUSH:  state_next = (32'(sp_reg) < SLOTS) ? S_W_HEAD : S_W_TOP;
            S_W_HEAD:  state_next = S_W_TOP;
            S_Q_RDA:   state_next = S_Q_RDB;
            S_Q_RDB:   state_next = S_Q_SET;
            S_Q_SET:   state_next = S_Q_UP;
            S_Q_UP:
                if (lvl_end) state_next = S_Q_EQ;
                else if (diff_shift[0]) state_next = S_Q_UPD;
            S_Q_UPD:   state_next = S_Q_UP;
            S_Q_EQ:    state_next = (u_reg == v_reg) ? S_Q_K : S_Q_LU;
            S_Q_LU:    state_next = S_Q_LV;
            S_Q_LV:    state_next = S_Q_LC;
            S_Q_LC:    state_next = (lvl_reg == '0) ? S_Q_LF : S_Q_LU;
            S_Q_LF:    state_next = S_Q_LFD;
            S_Q_LFD:   state_next = S_Q_K;
            S_Q_K:     state_next = k_ok ? S_Q_KU : S_REPLY;
            S_Q_KU:
                if (lvl_end) state_next = S_REPLY;
                else if (k_shift[0]) state_next = S_Q_KD;
            S_Q_KD:    state_next = S_Q_KU;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        ret_next        = ret_reg;
        node_count_next = node_count_reg;
        root_next       = root_reg;
        edge_count_next = edge_count_reg;
        built_next      = built_reg;
        clr_next        = clr_reg;
        sp_next         = sp_reg;
        done_next       = 1'b0;
        req_next        = req_reg;
        here_next       = here_reg;
        nb_next         = nb_reg;
        px_next         = px_reg;
        link_next       = link_reg;
        hdep_next       = hdep_reg;
        da_next         = da_reg;
        diff_next       = diff_reg;
        cur_next        = cur_reg;
        du_next         = du_reg;
        lvl_next        = lvl_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        lca_next        = lca_reg;
        kth_next        = kth_reg;
        found_next      = found_reg;
        st_next         = st_reg;
        result_next     = result_reg;

        head_we = 1'b0; head_waddr = '0; head_wdata = '0; head_raddr = '0;
        tgt_we  = 1'b0; edge_waddr = '0; tgt_wdata  = '0; nxt_wdata  = '0;
        edge_raddr = link_dec[$clog2(EDGE_CAP)-1:0];
        stk_we  = 1'b0; stk_waddr  = '0; stk_wdata  = '0; stk_raddr  = '0;
        anc_we  = 1'b0; anc_waddr  = '0; anc_wdata  = '0; anc_raddr  = '0;
        dep_we  = 1'b0; dep_waddr  = '0; dep_wdata  = '0; dep_raddr  = '0;

        // the user must send configuration writes only while idle; the block itself does not enforce this
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NODE_COUNT: node_count_next = cfg_data;
                CFG_ROOT_NODE:  root_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_INIT:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg[AW-1:0];
                clr_next   = clr_reg + TAW'(1);
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                end
            end
            S_DECODE:
            begin
                lca_next   = '0;
                kth_next   = '0;
                found_next = 1'b0;
                da_next    = '0;
                st_next    = ST_OK;
                clr_next   = '0;
                if (req_reg.action == ACT_ADD || req_reg.action == ACT_QUERY)
                begin
                    if (!a_ok || !b_ok) st_next = ST_BAD_NODE;
                    else if (req_reg.action == ACT_QUERY && !built_reg) st_next = ST_NOT_BUILT;
                end
                else if (req_reg.action == ACT_BUILD && !root_ok)
                begin
                    st_next = ST_BAD_NODE;
                end
            end
            S_REPLY:
            begin
                done_next                   = 1'b1;
                result_next.common_ancestor = lca_reg;
                result_next.kth_ancestor    = kth_reg;
                result_next.kth_found       = found_reg;
                result_next.depth_a         = NODE_W'(da_reg);
                result_next.status          = st_reg;
            end
            // edge insert: push onto the head of both adjacency lists
            S_E_RDA: head_raddr = AW'(req_reg.node_a);
            S_E_WRA:
            begin
                tgt_we     = 1'b1;
                edge_waddr = edge_count_reg[$clog2(EDGE_CAP)-1:0];
                tgt_wdata  = req_reg.node_b;
                nxt_wdata  = head_rdata;
                head_we    = 1'b1;
                head_waddr = AW'(req_reg.node_a);
                head_wdata = ec_inc;
            end
            S_E_RDB: head_raddr = AW'(req_reg.node_b);
            S_E_WRB:
            begin
                tgt_we          = 1'b1;
                edge_waddr      = ec_inc[$clog2(EDGE_CAP)-1:0];
                tgt_wdata       = req_reg.node_a;
                nxt_wdata       = head_rdata;
                head_we         = 1'b1;
                head_waddr      = AW'(req_reg.node_b);
                head_wdata      = ec_inc2;
                edge_count_next = ec_inc2;
                built_next      = 1'b0;
            end
            // build: sweep the table and depths to none / zero
            S_B_CLR:
            begin
                anc_we    = 1'b1;
                anc_waddr = clr_reg;
                if (clr_reg[TAW-1:AW] == '0)
                begin
                    dep_we    = 1'b1;
                    dep_waddr = clr_reg[AW-1:0];
                end
                clr_next = clr_reg + TAW'(1);
            end
            S_B_ROOT:
            begin
                px_next  = root_reg;
                cur_next = '{ok: 1'b1, node: '0};
                ret_next = S_B_HEAD;
            end
            S_B_HEAD: head_raddr = AW'(root_reg);
            S_B_HEADD:
            begin
                here_next = root_reg;
                hdep_next = '0;
                link_next = head_rdata;
                sp_next   = SW'(1);
            end
            S_B_DONE: built_next = 1'b1;
            // fill one node's lifting column, one level per read
            S_P_W0:
            begin
                anc_we    = 1'b1;
                anc_waddr = anc_addr('0, px_reg);
                anc_wdata = cur_reg;
                lvl_next  = LCW'(1);
            end
            S_P_CHK: anc_raddr = anc_addr(lvl_dec, cur_reg.node);
            S_P_WR:
            begin
                anc_we    = 1'b1;
                anc_waddr = anc_addr(lvl_reg, px_reg);
                anc_wdata = anc_rdata;
                cur_next  = anc_rdata;
                lvl_next  = lvl_reg + LCW'(1);
            end
            // depth-first walk; top of stack lives in registers
            S_W_TOP:
            begin
                if (link_end)
                begin
                    stk_raddr = sp_dec2[AW-1:0];
                    sp_next   = sp_dec;
                end
            end
            S_W_POP:
            begin
                here_next = stk_rdata[STK_W-1 -: NODE_W];
                link_next = stk_rdata[LW+DW-1 -: LW];
                hdep_next = stk_rdata[DW-1:0];
            end
            S_W_EDGE:
            begin
                link_next = nxt_rdata;
                nb_next   = tgt_rdata;
                anc_raddr = anc_addr('0, tgt_rdata);
            end
            S_W_VIS:
            begin
                if (!anc_rdata.ok)
                begin
                    dep_we    = 1'b1;
                    dep_waddr = AW'(nb_reg);
                    dep_wdata = hdep_reg + DW'(1);
                    px_next   = nb_reg;
                    cur_next  = '{ok: 1'b1, node: here_reg};
                    ret_next  = S_W_PUSH;
                end
            end
            S_W_PUSH:
            begin
                if (32'(sp_reg) < SLOTS)
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = sp_dec[AW-1:0];
                    stk_wdata  = {here_reg, link_reg, hdep_reg};
                    here_next  = nb_reg;
                    hdep_next  = hdep_reg + DW'(1);
                    head_raddr = AW'(nb_reg);
                end
            end
            S_W_HEAD:
            begin
                link_next = head_rdata;
                sp_next   = sp_reg + SW'(1);
            end
            // query: equalise depths, lift both, then k-th ancestor
            S_Q_RDA: dep_raddr = AW'(req_reg.node_a);
            S_Q_RDB:
            begin
                da_next   = dep_rdata;
                dep_raddr = AW'(req_reg.node_b);
            end
            S_Q_SET:
            begin
                if (da_reg < db)
                begin
                    u_next    = req_reg.node_b;
                    v_next    = req_reg.node_a;
                    diff_next = db - da_reg;
                end
                else
                begin
                    u_next    = req_reg.node_a;
                    v_next    = req_reg.node_b;
                    diff_next = da_reg - db;
                end
                lvl_next = '0;
            end
            S_Q_UP:
            begin
                anc_raddr = anc_addr(lvl_reg, u_reg);
                if (!lvl_end && !diff_shift[0]) lvl_next = lvl_reg + LCW'(1);
            end
            S_Q_UPD:
            begin
                u_next   = anc_rdata.node;
                lvl_next = lvl_reg + LCW'(1);
            end
            S_Q_EQ:
            begin
                lca_next = u_reg;
                lvl_next = LCW'(LEVELS - 1);
            end
            S_Q_LU: anc_raddr = anc_addr(lvl_reg, u_reg);
            S_Q_LV:
            begin
                du_next   = anc_rdata;
                anc_raddr = anc_addr(lvl_reg, v_reg);
            end
            S_Q_LC:
            begin
                if (du_reg != anc_rdata)
                begin
                    u_next = du_reg.node;
                    v_next = anc_rdata.node;
                end
                if (lvl_reg != '0) lvl_next = lvl_dec;
            end
            S_Q_LF: anc_raddr = anc_addr('0, u_reg);
            S_Q_LFD: lca_next = anc_rdata.node;
            S_Q_K:
            begin
                u_next   = req_reg.node_a;
                lvl_next = '0;
            end
            S_Q_KU:
            begin
                anc_raddr = anc_addr(lvl_reg, u_reg);
                if (lvl_end)
                begin
                    kth_next   = u_reg;
                    found_next = 1'b1;
                end
                else if (!k_shift[0])
                begin
                    lvl_next = lvl_reg + LCW'(1);
                end
            end
            S_Q_KD:
            begin
                u_next   = anc_rdata.node;
                lvl_next = lvl_reg + LCW'(1);
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            ret_reg        <= S_IDLE;
            node_count_reg <= NODE_W'(1);
            root_reg       <= NODE_W'(1);
            edge_count_reg <= '0;
            built_reg      <= 1'b0;
            clr_reg        <= '0;
            sp_reg         <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            node_count_reg <= node_count_next;
            root_reg       <= root_next;
            edge_count_reg <= edge_count_next;
            built_reg      <= built_next;
            clr_reg        <= clr_next;
            sp_reg         <= sp_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        here_reg   <= here_next;
        nb_reg     <= nb_next;
        px_reg     <= px_next;
        link_reg   <= link_next;
        hdep_reg   <= hdep_next;
        da_reg     <= da_next;
        diff_reg   <= diff_next;
        cur_reg    <= cur_next;
        du_reg     <= du_next;
        lvl_reg    <= lvl_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        lca_reg    <= lca_next;
        kth_reg    <= kth_next;
        found_reg  <= found_next;
        st_reg     <= st_next;
        result_reg <= result_next;
    end

    // Checks
    `TLCA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `TLCA_ASSERT_NXT(a_single_strobe, done, !done)
    `TLCA_ASSERT_IMP(a_error_clean, done && (result.status != ST_OK), (result.common_ancestor == '0) && !result.kth_found)
    `TLCA_ASSERT_IMP(a_edge_cap, 1'b1, 32'(edge_count_reg) <= EDGE_CAP)

endmodule
`default_nettype wire

[tb/tb_tree_lca_binary_lifting_core.sv]
// Testbench for tree_lca_binary_lifting_core: directed table, then phased random traffic.
// Depends on tlca_pkg and the core RTL; checks every result against an in-bench predictor or a typed result.
`timescale 1ns / 1ps
module tb_tree_lca_binary_lifting_core;
    import tlca_pkg::*;

    localparam int SLOTS    = 1024;
    localparam int EDGE_CAP = 2 * SLOTS;
    localparam int LVLS     = LEVELS_DEF;
    localparam int STALL_LIMIT = 300000;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    req_t           request;
    logic           done;
    res_t           result;
    logic           cfg_valid;
    logic           cfg_ready;
    cfg_idx_t       cfg_index;
    logic [NODE_W-1:0] cfg_data;

    tree_lca_binary_lifting_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor state: a private copy of the lifting table, depths,
    // adjacency lists and configuration.
    // ---------------------------------------------------------------
    logic [NODE_W-1:0] lift_node [LVLS][SLOTS];
    bit                lift_ok   [LVLS][SLOTS];
    int unsigned       depth_of  [SLOTS];
    int unsigned       head_link [SLOTS];    // edge index + 1, 0 = empty list
    int unsigned       edge_to   [EDGE_CAP];
    int unsigned       edge_link [EDGE_CAP];
    int unsigned       n_edges;
    bit                tree_ready;
    int unsigned       cfg_nodes;
    int unsigned       cfg_root;

    res_t        pending_results [$];
    int          mismatches;
    int          stall_cycles;

    function automatic bit node_ok(int unsigned x);
        return x >= 1 && x <= cfg_nodes;    // 10-bit register never exceeds 1023
    endfunction

    function automatic void link_parent(int unsigned x, int unsigned par);
        int unsigned mid;
        lift_node[0][x] = par[NODE_W-1:0];
        lift_ok[0][x]   = 1'b1;
        for (int i = 1; i < LVLS; i++) begin
            if (lift_ok[i-1][x]) begin
                mid = lift_node[i-1][x];
                lift_node[i][x] = lift_node[i-1][mid];
                lift_ok[i][x]   = lift_ok[i-1][mid];
            end else begin
                lift_node[i][x] = '0;
                lift_ok[i][x]   = 1'b0;
            end
        end
    endfunction

    // Depth-first walk from the root, newest edge first; skip reached or
    // out-of-range neighbours so cycles and duplicate edges do no harm.
    function automatic void walk_tree(int unsigned root);
        int unsigned stk_node [SLOTS];
        int unsigned stk_cur  [SLOTS];
        int unsigned sp, here, lnk, nb;
        for (int i = 0; i < LVLS; i++)
            for (int x = 0; x < SLOTS; x++) begin
                lift_node[i][x] = '0;
                lift_ok[i][x]   = 1'b0;
            end
        for (int x = 0; x < SLOTS; x++) depth_of[x] = 0;
        link_parent(root, 0);
        stk_node[0] = root;
        stk_cur[0]  = head_link[root];
        sp = 1;
        while (sp > 0) begin
            here = stk_node[sp-1];
            lnk  = stk_cur[sp-1];
            if (lnk == 0 || lnk > n_edges) begin
                sp--;
            end else begin
                stk_cur[sp-1] = edge_link[lnk-1];
                nb = edge_to[lnk-1];
                if (node_ok(nb) && !lift_ok[0][nb]) begin
                    depth_of[nb] = depth_of[here] + 1;
                    link_parent(nb, here);
                    if (sp < SLOTS) begin
                        stk_node[sp] = nb;
                        stk_cur[sp]  = head_link[nb];
                        sp++;
                    end
                end
            end
        end
    endfunction

    function automatic int unsigned common_ancestor_of(int unsigned a, int unsigned b);
        int unsigned u, v, t, diff;
        u = a;
        v = b;
        if (depth_of[u] < depth_of[v]) begin
            t = u; u = v; v = t;
        end
        diff = depth_of[u] - depth_of[v];
        for (int i = 0; i < LVLS; i++)
            if (diff[i]) u = lift_node[i][u];
        if (u == v) return u;
        for (int i = LVLS - 1; i >= 0; i--) begin
            if (lift_node[i][u] != lift_node[i][v] || lift_ok[i][u] != lift_ok[i][v]) begin
                u = lift_node[i][u];
                v = lift_node[i][v];
            end
        end
        return lift_node[0][u];
    endfunction

    // Advance the predictor by one request; return 1 when a result is due.
    function automatic bit predict_result(req_t r, output res_t o);
        int unsigned a, b, k, u;
        a = r.node_a;
        b = r.node_b;
        k = r.steps;
        o = '0;
        case (action_t'(r.action))
            ACT_NOP: return 1'b0;
            ACT_ADD: begin
                if (!node_ok(a) || !node_ok(b)) begin
                    o.status = ST_BAD_NODE;
                end else if (n_edges + 2 <= EDGE_CAP) begin
                    edge_to[n_edges]   = b;
                    edge_link[n_edges] = head_link[a];
                    head_link[a]       = n_edges + 1;
                    n_edges++;
                    edge_to[n_edges]   = a;
                    edge_link[n_edges] = head_link[b];
                    head_link[b]       = n_edges + 1;
                    n_edges++;
                    tree_ready = 1'b0;
                end
            end
            ACT_BUILD: begin
                if (!node_ok(cfg_root)) begin
                    o.status = ST_BAD_NODE;
                end else begin
                    walk_tree(cfg_root);
                    tree_ready = 1'b1;
                end
            end
            default: begin
                if (!node_ok(a) || !node_ok(b)) begin
                    o.status = ST_BAD_NODE;
                end else if (!tree_ready) begin
                    o.status = ST_NOT_BUILT;
                end else begin
                    o.common_ancestor = NODE_W'(common_ancestor_of(a, b));
                    if (k <= depth_of[a]) begin
                        u = a;
                        for (int i = 0; i < LVLS; i++)
                            if (k[i]) u = lift_node[i][u];
                        o.kth_ancestor = NODE_W'(u);
                        o.kth_found    = 1'b1;
                    end
                    o.depth_a = NODE_W'(depth_of[a]);
                end
            end
        endcase
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    bit no_gaps;

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Hold start low for the gap, then offer the request until it is taken.
    // A result typed in by hand overrides the predicted one.
    task automatic issue(req_t r, bit typed = 1'b0, res_t typed_res = '0);
        int   gap;
        res_t exp_res;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        if (predict_result(r, exp_res))
            pending_results = {pending_results, (typed ? typed_res : exp_res)};
    endtask

    task automatic send(action_t act, int unsigned a, int unsigned b, int unsigned k);
        req_t r;
        r.action = act;
        r.node_a = a[NODE_W-1:0];
        r.node_b = b[NODE_W-1:0];
        r.steps  = k[STEPS_W-1:0];
        issue(r);
    endtask

    // Drain every outstanding result, let a trailing no-op settle, then write.
    task automatic write_reg(cfg_idx_t idx, int unsigned val);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        while (busy) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[NODE_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_NODE_COUNT) cfg_nodes = val & 10'h3FF;
        else                       cfg_root  = val & 10'h3FF;
    endtask

    // ---------------------------------------------------------------
    // Result checker: compare each strobed result with the oldest request
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        res_t e;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, result);
                mismatches++;
            end else begin
                e = pending_results.pop_front();
                if (result.common_ancestor !== e.common_ancestor)
                    $display("%0t: common_ancestor expected %0d got %0d",
                             $time, e.common_ancestor, result.common_ancestor);
                if (result.kth_ancestor !== e.kth_ancestor)
                    $display("%0t: kth_ancestor expected %0d got %0d",
                             $time, e.kth_ancestor, result.kth_ancestor);
                if (result.kth_found !== e.kth_found)
                    $display("%0t: kth_found expected %0d got %0d",
                             $time, e.kth_found, result.kth_found);
                if (result.depth_a !== e.depth_a)
                    $display("%0t: depth_a expected %0d got %0d",
                             $time, e.depth_a, result.depth_a);
                if (result.status !== e.status)
                    $display("%0t: status expected %0d got %0d",
                             $time, e.status, result.status);
                if (result !== e) mismatches++;
            end
        end
    end

    // Watchdog: a long build sweeps the whole table, so allow a generous stall.
    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Directed table, run straight after reset (node_count 1, root 1)
    // ---------------------------------------------------------------
    typedef struct {
        action_t     act;
        int unsigned a, b, k;
        res_t        res;
    } step_row_t;

    localparam res_t R_OK    = '{default: '0};
    localparam res_t R_BAD   = '{status: ST_BAD_NODE, default: '0};
    localparam res_t R_STALE = '{status: ST_NOT_BUILT, default: '0};
    // Single-node tree built at node 1: it is its own ancestor at step 0.
    localparam res_t R_SELF0 = '{common_ancestor: 10'd1, kth_ancestor: 10'd1,
                                 kth_found: 1'b1, default: '0};
    localparam res_t R_SELF_NONE = '{common_ancestor: 10'd1, default: '0};

    step_row_t directed [] = '{
        '{ACT_QUERY, 1,    1,    0,    R_STALE},     // table not built yet
        '{ACT_QUERY, 0,    1,    0,    R_BAD},       // node 0 is out of range
        '{ACT_QUERY, 1,    1023, 1023, R_BAD},
        '{ACT_QUERY, 1023, 0,    0,    R_BAD},
        '{ACT_ADD,   2,    1,    0,    R_BAD},       // bad edge end
        '{ACT_ADD,   0,    0,    0,    R_BAD},
        '{ACT_ADD,   1023, 1023, 1023, R_BAD},
        '{ACT_NOP,   1023, 1023, 1023, R_OK},        // no result
        '{ACT_ADD,   1,    1,    0,    R_OK},        // self loop is stored
        '{ACT_QUERY, 1,    1,    0,    R_STALE},     // stored edge made it stale
        '{ACT_BUILD, 0,    0,    0,    R_OK},
        '{ACT_QUERY, 1,    1,    0,    R_SELF0},
        '{ACT_QUERY, 1,    1,    1,    R_SELF_NONE}, // steps beyond depth
        '{ACT_QUERY, 1,    1,    1023, R_SELF_NONE}, // all step bits set, still beyond depth
        '{ACT_QUERY, 1,    1,    512,  R_SELF_NONE},
        '{ACT_NOP,   0,    0,    0,    R_OK},
        '{ACT_BUILD, 1023, 1023, 1023, R_OK},
        '{ACT_QUERY, 1,    1,    0,    R_SELF0}
    };

    // ---------------------------------------------------------------
    // Random phase: grow a tree among nodes 1..n, build, then query
    // ---------------------------------------------------------------
    task automatic run_phase(int unsigned n, int unsigned root, int n_edges_new, int n_queries);
        int unsigned members [$];
        int unsigned lim, x, y, a, b, k;
        int r;
        write_reg(CFG_NODE_COUNT, n);
        write_reg(CFG_ROOT_NODE, root);
        no_gaps = ($urandom_range(0, 3) == 0);
        lim = (n == 0) ? 1 : n;
        members = {members, ((root >= 1 && root <= lim) ? root : 1)};
        for (int e = 0; e < n_edges_new; e++) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                x = $urandom_range(1, lim);
                y = members[$urandom_range(0, members.size() - 1)];
                members = {members, x};
                if (r < 40) send(ACT_ADD, x, y, $urandom);
                else        send(ACT_ADD, y, x, $urandom);
            end else if (r < 88) begin
                send(ACT_ADD, $urandom, $urandom, $urandom);       // noise, mostly bad
            end else if (r < 94) begin
                send(ACT_QUERY, $urandom_range(1, lim), $urandom_range(1, lim), 0);
            end else begin
                send(ACT_NOP, $urandom, $urandom, $urandom);
            end
        end
        send(ACT_BUILD, $urandom, $urandom, $urandom);
        for (int q = 0; q < n_queries; q++) begin
            r = $urandom_range(0, 99);
            a = (r < 90) ? members[$urandom_range(0, members.size() - 1)] : $urandom;
            b = ($urandom_range(0, 9) != 0) ? $urandom_range(1, lim) : $urandom;
            a &= 10'h3FF;
            k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, depth_of[a] + 1) : $urandom;
            if (r >= 97) send(ACT_NOP, a, b, k);
            else         send(ACT_QUERY, a, b, k);
        end
        // Once in a while rebuild without new edges and query again.
        if ($urandom_range(0, 2) == 0) begin
            send(ACT_BUILD, 0, 0, 0);
            for (int q = 0; q < 5; q++)
                send(ACT_QUERY, $urandom_range(1, lim), $urandom_range(1, lim), $urandom_range(0, 4));
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_NODE_COUNT;
        cfg_data   = '0;
        mismatches = 0;
        stall_cycles = 0;
        no_gaps    = 1'b0;
        for (int i = 0; i < LVLS; i++)
            for (int x = 0; x < SLOTS; x++) begin
                lift_node[i][x] = '0;
                lift_ok[i][x]   = 1'b0;
            end
        for (int x = 0; x < SLOTS; x++) begin
            depth_of[x]  = 0;
            head_link[x] = 0;
        end
        n_edges    = 0;
        tree_ready = 1'b0;
        cfg_nodes  = 1;
        cfg_root   = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i]) begin
            req_t r;
            r.action = directed[i].act;
            r.node_a = directed[i].a[NODE_W-1:0];
            r.node_b = directed[i].b[NODE_W-1:0];
            r.steps  = directed[i].k[STEPS_W-1:0];
            issue(r, 1'b1, directed[i].res);
        end

        // Walk the configuration extremes: no nodes, the full range, root at
        // the top, and a root outside the range so the build is refused.
        run_phase(5,    1,    6,  40);
        run_phase(40,   7,    25, 50);
        run_phase(0,    1,    8,  20);
        run_phase(200,  200,  25, 50);
        run_phase(1023, 1023, 25, 50);
        run_phase(12,   0,    10, 25);
        run_phase(1,    1,    4,  20);
        run_phase(300,  3,    25, 50);

        // Fill the edge store past capacity; the overflow edges are dropped.
        write_reg(CFG_NODE_COUNT, 1023);
        write_reg(CFG_ROOT_NODE, 1);
        no_gaps = 1'b0;
        while (n_edges + 2 <= EDGE_CAP)
            send(ACT_ADD, $urandom_range(1, 1023), $urandom_range(1, 1023), $urandom);
        for (int i = 0; i < 6; i++)
            send(ACT_ADD, $urandom_range(1, 1023), $urandom_range(1, 1023), $urandom);
        send(ACT_BUILD, 0, 0, 0);
        for (int q = 0; q < 40; q++) begin
            int unsigned a;
            a = $urandom_range(1, 1023);
            send(ACT_QUERY, a, $urandom_range(1, 1023), $urandom_range(0, depth_of[a] + 1));
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[tree_lca_binary_lifting_core.f]
+incdir+src
src/tlca_pkg.sv
src/tlca_ram.sv
src/tree_lca_binary_lifting_core.sv
tb/tb_tree_lca_binary_lifting_core.sv
